// ===== sv/srl_pkg.sv =====
// Shared constants, codes and types of the sorted record list.
package srl_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEY_W  = 32;
    localparam int TAG_W  = 64;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int FILL_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Per-cycle operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [TAG_W-1:0] tag;
    } t_rec;

    typedef struct packed {
        logic m;   // slot free or stored key greater than the command key
        logic eq;  // occupied and stored key == command key
    } t_cell_flags;

    typedef struct packed {
        t_cell_op                op;
        logic signed [KEY_W-1:0] key;
        logic        [TAG_W-1:0] tag;
    } t_cell_ctl;

endpackage

// ===== sv/srl_if.sv =====
// Handshake channels: command items in, result items out.
interface srl_in_if;
    logic                          valid;
    logic                          ready;
    logic [srl_pkg::CMD_W-1:0]     command;
    logic signed [srl_pkg::KEY_W-1:0] key;
    logic [srl_pkg::TAG_W-1:0]     tag;

    modport source (output valid, command, key, tag, input ready);
    modport sink   (input valid, command, key, tag, output ready);
endinterface

interface srl_out_if;
    logic                          valid;
    logic                          ready;
    logic [srl_pkg::STAT_W-1:0]    status;
    logic signed [srl_pkg::KEY_W-1:0] out_key;
    logic [srl_pkg::TAG_W-1:0]     out_tag;
    logic                          last;
    logic [srl_pkg::FILL_W-1:0]    fill;

    modport source (output valid, status, out_key, out_tag, last, fill, input ready);
    modport sink   (input valid, status, out_key, out_tag, last, fill, output ready);
endinterface

// ===== sv/srl_cell.sv =====
// One storage cell of the sorted chain: holds a record, shifts with its neighbours.
module srl_cell (
    input  logic                i_clk,
    input  srl_pkg::t_cell_ctl  i_ctl,
    input  logic                i_valid,
    input  logic                i_next_valid,
    input  logic                i_prev_m,
    input  srl_pkg::t_rec       i_prev,
    input  srl_pkg::t_rec       i_next,
    input  srl_pkg::t_rec       i_head,
    output srl_pkg::t_rec       o_rec,
    output srl_pkg::t_cell_flags o_flags
);
    import srl_pkg::*;

    t_rec r_rec;
    t_rec n_rec;
    logic w_m;
    logic w_ge;
    logic w_eq;

    assign w_m  = !i_valid || (r_rec.key > i_ctl.key);
    assign w_ge = i_valid && (r_rec.key >= i_ctl.key);
    assign w_eq = i_valid && (r_rec.key == i_ctl.key);

    assign o_flags = '{m: w_m, eq: w_eq};
    assign o_rec   = r_rec;

    always_comb begin
        n_rec = r_rec;
        unique case (i_ctl.op)
            OP_HOLD: begin
            end
            OP_INSERT: begin
                // neighbour below is shifting up: take its record
                if (i_prev_m) begin
                    n_rec = i_prev;
                end else if (w_m) begin
                    n_rec = '{key: i_ctl.key, tag: i_ctl.tag};
                end
            end
            OP_DELETE: begin
                if (w_ge) begin
                    n_rec = i_next;
                end
            end
            OP_ROTATE: begin
                // last occupied cell receives the head record
                if (i_valid && !i_next_valid) begin
                    n_rec = i_head;
                end else if (i_valid) begin
                    n_rec = i_next;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

// ===== sv/sorted_record_list.sv =====
// Top level of the sorted record list: chain of record cells and its sequencer.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------------
//  i_cmd   | in  | valid / ready       | command, key, tag
//  o_res   | out | valid / ready       | status, out_key, out_tag, last, fill
//
// Insert and delete pass an accept step and then the execute step, in which every
// cell compares its key and shifts in parallel.
// Read-all rotates the chain one record per cycle past cell 0, which feeds the output
// register, so the order is restored at the end; a stalled output pauses the rotation.
// Reset (synchronous, active low) empties the store at once; no clearing pass.
// A stalled output holds the result register; a new item may still be accepted
// while it waits, and execution pauses until the register frees up.
module sorted_record_list (
    input  logic i_clk,
    input  logic i_rst_n,
    srl_in_if.sink    i_cmd,
    srl_out_if.source o_res
);
    import srl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state r_state, n_state;

    // latched command item
    t_cmd                    r_cmd;
    logic signed [KEY_W-1:0] r_key;
    logic        [TAG_W-1:0] r_tag;

    logic [CNT_W-1:0] r_count, n_count;   // records stored
    logic [CNT_W-1:0] r_idx,   n_idx;     // records sent during read-all

    // output register
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status, n_out_status;
    t_rec             r_out_rec, n_out_rec;
    logic             r_out_last, n_out_last;

    // chain wiring
    t_cell_ctl        w_ctl;
    t_rec             w_rec   [DEPTH];
    t_cell_flags      w_flags [DEPTH];
    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_eq;
    logic             w_found;
    logic             w_full;
    logic             w_out_free;
    logic             w_accept;

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_found    = |w_eq;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_rec w_prev;
            t_rec w_next;
            logic w_prev_m;
            logic w_next_valid;

            assign w_valid[gi] = (CNT_W'(gi) < r_count);
            assign w_eq[gi]    = w_flags[gi].eq;

            if (gi == 0) begin : g_first
                assign w_prev   = '0;
                assign w_prev_m = 1'b0;
            end else begin : g_mid
                assign w_prev   = w_rec[gi-1];
                assign w_prev_m = w_flags[gi-1].m;
            end

            if (gi == DEPTH - 1) begin : g_last
                assign w_next       = '0;
                assign w_next_valid = 1'b0;
            end else begin : g_body
                assign w_next       = w_rec[gi+1];
                assign w_next_valid = w_valid[gi+1];
            end

            srl_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_valid      (w_valid[gi]),
                .i_next_valid (w_next_valid),
                .i_prev_m     (w_prev_m),
                .i_prev       (w_prev),
                .i_next       (w_next),
                .i_head       (w_rec[0]),
                .o_rec        (w_rec[gi]),
                .o_flags      (w_flags[gi])
            );
        end
    endgenerate

    assign i_cmd.ready = (r_state == S_IDLE);

    assign o_res.valid   = r_out_valid;
    assign o_res.status  = r_out_status;
    assign o_res.out_key = r_out_rec.key;
    assign o_res.out_tag = r_out_rec.tag;
    assign o_res.last    = r_out_last;
    assign o_res.fill    = FILL_W'(r_count);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_rec    = r_out_rec;
        n_out_last   = r_out_last;
        w_ctl        = '{op: OP_HOLD, key: r_key, tag: r_tag};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_out_rec  = '0;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                    unique case (r_cmd)
                        CMD_INSERT: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_out_status = ST_OK;
                                w_ctl.op     = OP_INSERT;
                                n_count      = r_count + CNT_W'(1);
                            end
                        end
                        CMD_DELETE: begin
                            n_out_valid = 1'b1;
                            if (w_found) begin
                                n_out_status = ST_OK;
                                w_ctl.op     = OP_DELETE;
                                n_count      = r_count - CNT_W'(1);
                            end else begin
                                n_out_status = ST_NOT_FOUND;
                            end
                        end
                        CMD_READ: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                            end else begin
                                // records stream out from the read state
                                n_idx   = '0;
                                n_state = S_READ;
                            end
                        end
                        CMD_NOP: begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    w_ctl.op     = OP_ROTATE;
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_rec    = w_rec[0];
                    n_out_last   = (r_idx == r_count - CNT_W'(1));
                    n_idx        = r_idx + CNT_W'(1);
                    if (r_idx == r_count - CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= t_cmd'(i_cmd.command);
            r_key <= i_cmd.key;
            r_tag <= i_cmd.tag;
        end
        r_out_status <= n_out_status;
        r_out_rec    <= n_out_rec;
        r_out_last   <= n_out_last;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("record count above depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_EXEC)
        else $error("accepted item not executed next");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_count == $past(r_count) || r_count == $past(r_count) + CNT_W'(1)
             || r_count == $past(r_count) - CNT_W'(1)))
        else $error("record count moved by more than one");

    a_read_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> r_idx < r_count)
        else $error("read-out index past the stored records");

    a_read_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ && n_state == S_READ |=> $stable(r_count))
        else $error("record count changed during read-out");
`endif

endmodule

// ===== dv/sorted_record_list_tb.sv =====
`timescale 1ns / 1ps
// Testbench of the sorted record list: directed and random command items checked against a queue-based store.
module sorted_record_list_tb;
    import srl_pkg::*;

    localparam int IDLE_LIMIT  = 3000;  // cycles with no item moving on either side
    localparam int N_RANDOM    = 350;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off, backs the input up

    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    typedef struct {
        t_status                 status;
        logic signed [KEY_W-1:0] key;
        logic        [TAG_W-1:0] tag;
        logic                    last;
        logic       [FILL_W-1:0] fill;
    } t_result;

    // Scoreboard: keeps its own sorted copy of the store and the results still owed
    class record_list_checker;
        logic signed [KEY_W-1:0] keys[$];
        logic        [TAG_W-1:0] tags[$];
        t_result                 owed[$];
        int                      n_fail;

        function void owe(t_status st, logic signed [KEY_W-1:0] k,
                          logic [TAG_W-1:0] t, logic lst);
            t_result r;
            r.status = st;
            r.key    = k;
            r.tag    = t;
            r.last   = lst;
            r.fill   = FILL_W'(keys.size());
            owed.push_back(r);
        endfunction

        function void take_command(t_cmd cmd, logic signed [KEY_W-1:0] k,
                                   logic [TAG_W-1:0] t);
            int pos;
            pos = -1;
            case (cmd)
                CMD_INSERT: begin
                    if (keys.size() >= DEPTH) begin
                        owe(ST_FULL, '0, '0, 1'b1);
                    end else begin
                        // ahead of the first strictly greater key: equal keys keep arrival order
                        pos = keys.size();
                        for (int i = 0; i < keys.size(); i++) begin
                            if (keys[i] > k) begin
                                pos = i;
                                break;
                            end
                        end
                        keys.insert(pos, k);
                        tags.insert(pos, t);
                        owe(ST_OK, '0, '0, 1'b1);
                    end
                end
                CMD_DELETE: begin
                    for (int i = 0; i < keys.size(); i++) begin
                        if (keys[i] == k) begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos < 0) begin
                        owe(ST_NOT_FOUND, '0, '0, 1'b1);
                    end else begin
                        keys.delete(pos);
                        tags.delete(pos);
                        owe(ST_OK, '0, '0, 1'b1);
                    end
                end
                CMD_READ: begin
                    if (keys.size() == 0) begin
                        owe(ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < keys.size(); i++)
                            owe(ST_OK, keys[i], tags[i], i == keys.size() - 1);
                    end
                end
                default: owe(ST_OK, '0, '0, 1'b1);  // NOP: no change, current fill
            endcase
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic signed [KEY_W-1:0] k,
                                   logic [TAG_W-1:0] t, logic lst, logic [FILL_W-1:0] f);
            t_result e;
            if (owed.size() == 0) begin
                $error("result item with nothing outstanding: status %0d key %0d", st, k);
                n_fail++;
                return;
            end
            e = owed.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                n_fail++;
            end
            if (k !== e.key) begin
                $error("out_key: expected %0d, got %0d", e.key, k);
                n_fail++;
            end
            if (t !== e.tag) begin
                $error("out_tag: expected %h, got %h", e.tag, t);
                n_fail++;
            end
            if (lst !== e.last) begin
                $error("last: expected %0b, got %0b", e.last, lst);
                n_fail++;
            end
            if (f !== e.fill) begin
                $error("fill: expected %0d, got %0d", e.fill, f);
                n_fail++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    srl_in_if  cmd_if ();
    srl_out_if res_if ();

    sorted_record_list u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    always #2 i_clk = ~i_clk;

    record_list_checker chk;
    int n_sent      = 0;
    bit send_steady = 1'b0;
    bit hold_off    = 1'b0;
    int idle_cycles = 0;

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic signed [KEY_W-1:0] insert_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30 && chk.keys.size() > 0)
            return chk.keys[$urandom_range(0, chk.keys.size() - 1)];  // duplicate key
        if (r < 40) begin
            case ($urandom_range(0, 3))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        if (r < 60) return $urandom_range(0, 15) - 8;
        return $urandom();
    endfunction

    function automatic logic signed [KEY_W-1:0] delete_key();
        if (chk.keys.size() > 0 && $urandom_range(0, 3) != 0)
            return chk.keys[$urandom_range(0, chk.keys.size() - 1)];
        return insert_key();  // mostly absent keys
    endfunction

    function automatic logic [TAG_W-1:0] any_tag();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Offer one command item, note it in the scoreboard once accepted
    task automatic send_cmd(input t_cmd cmd, input logic signed [KEY_W-1:0] k,
                            input logic [TAG_W-1:0] t);
        int gap;
        gap = send_steady ? 0 : idle_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.key     <= k;
        cmd_if.tag     <= t;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        chk.take_command(cmd, k, t);
        n_sent++;
    endtask

    // Result side: random stalls, calm windows, and the long hold-off on request
    initial begin : result_sink
        int stall;
        int cyc;
        stall = 0;
        cyc   = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_off) begin
                res_if.ready <= 1'b0;
            end else if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
                if ((cyc / 600) % 3 != 2) stall = idle_gap();
            end
        end
    end

    // Once traffic is going, hold results off long enough for the input to back up
    initial begin : long_hold
        wait (n_sent >= 150);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            chk.check_result(res_if.status, res_if.out_key, res_if.out_tag,
                             res_if.last, res_if.fill);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        bit grow;
        int r;
        chk  = new();
        grow = 1'b1;
        i_rst_n        <= 1'b0;
        cmd_if.valid   <= 1'b0;
        cmd_if.command <= CMD_NOP;
        cmd_if.key     <= '0;
        cmd_if.tag     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, each command, extremes, equal keys, full store
        send_cmd(CMD_READ,   '0, '0);
        send_cmd(CMD_DELETE, 7, '1);
        send_cmd(CMD_NOP,    '1, '1);
        send_cmd(CMD_INSERT, KEY_MAX, '1);
        send_cmd(CMD_INSERT, KEY_MIN, '0);
        send_cmd(CMD_INSERT, 0, 64'h1111_1111_1111_1111);
        send_cmd(CMD_INSERT, 0, 64'h2222_2222_2222_2222);  // equal key goes behind
        send_cmd(CMD_INSERT, -1, 64'h8000_0000_0000_0001);
        send_cmd(CMD_READ,   KEY_MIN, '1);
        send_cmd(CMD_DELETE, 0, '0);                        // first of the equal pair
        send_cmd(CMD_DELETE, KEY_MIN, '1);
        while (chk.keys.size() < DEPTH)
            send_cmd(CMD_INSERT, $urandom_range(0, 9) - 5, any_tag());
        send_cmd(CMD_INSERT, KEY_MAX, '1);                  // store full
        send_cmd(CMD_READ,   '0, '0);

        // random: drift between filling and draining so every fill level is visited
        for (int n = 0; n < N_RANDOM; n++) begin
            send_steady = ((n / 40) % 4 == 2);
            if (chk.keys.size() >= DEPTH) grow = 1'b0;
            else if (chk.keys.size() == 0) grow = 1'b1;
            else if ($urandom_range(0, 39) == 0) grow = !grow;
            r = $urandom_range(0, 99);
            if (r < (grow ? 62 : 20))
                send_cmd(CMD_INSERT, insert_key(), any_tag());
            else if (r < (grow ? 80 : 78))
                send_cmd(CMD_DELETE, delete_key(), any_tag());
            else if (r < 96)
                send_cmd(CMD_READ, $urandom(), any_tag());
            else
                send_cmd(CMD_NOP, $urandom(), any_tag());
        end
        cmd_if.valid <= 1'b0;

        while (chk.owed.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (chk.n_fail == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
